>>> src/ooke_pkg.sv
// Shared types and constants for the on-off keyed pulse train encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ooke_pkg;

    // Message word length and derived widths.
    localparam int WORD_BITS = 32;
    localparam int BITPOS_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int IN_WORD_W = 32;

    // Timing register widths.
    localparam int UNIT_W = 16;
    localparam int GAP_W  = 20;
    localparam int REP_W  = 8;
    localparam int TICK_W = 20;
    // One bit of headroom over the widest segment length and tick count.
    localparam int LEN_W  = 21;

    // Long data segments last this many units.
    localparam int LONG_UNITS = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_GAP_TICKS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_GAP_TICKS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT    = CFG_IDX_W'(3);

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RST      = UNIT_W'(250);
    localparam logic [GAP_W-1:0]  START_GAP_TICKS_RST = GAP_W'(2500);
    localparam logic [GAP_W-1:0]  STOP_GAP_TICKS_RST  = GAP_W'(10000);
    localparam logic [REP_W-1:0]  REPEAT_COUNT_RST    = REP_W'(5);

    // Request types carried on the input channel.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // Live configuration seen by the sequencer.
    typedef struct packed {
        logic [UNIT_W-1:0] unit_ticks;
        logic [GAP_W-1:0]  start_gap_ticks;
        logic [GAP_W-1:0]  stop_gap_ticks;
        logic [REP_W-1:0]  repeat_count;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic accepted;
        logic all_done;
    } res_t;

endpackage

>>> src/ook_pulse_train_encoder_core.sv
// Top level of the on-off keyed pulse train encoder.
// Depends on ooke_pkg, ooke_cfg_regs, ooke_seq and ooke_out_buf.
//
//   channel   direction  handshake             payload
//   s_        in         s_valid / s_ready     s_req_type, s_word
//   m_        out        m_valid / m_ready     m_pin_level, m_busy_res, m_accepted, m_all_done
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every input beat yields one result beat. A beat is resolved in the cycle it
// is accepted and its result is visible on the next cycle; one beat per clock while s_ready is high.
// A two-entry result buffer keeps s_ready high while one result waits.
// s_ready drops only when both buffer entries are occupied.
// Reset (aresetn low, synchronous) clears the sequencer, loads the timing
// registers with their defaults and empties the result buffer.
`timescale 1ns / 1ps

module ook_pulse_train_encoder_core
    import ooke_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [IN_WORD_W-1:0]  s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_pin_level,
    output logic                  m_busy_res,
    output logic                  m_accepted,
    output logic                  m_all_done,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t step_res;
    res_t out_res;
    logic step_en;
    logic buf_not_full;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;
    assign s_ready   = buf_not_full;
    assign step_en   = s_valid && s_ready;

    ooke_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ooke_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_en),
        .req_type (s_req_type),
        .word     (s_word),
        .cfg      (cfg),
        .res      (step_res)
    );

    ooke_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (step_en),
        .wr_data  (step_res),
        .not_full (buf_not_full),
        .rd_valid (m_valid),
        .rd_en    (m_ready),
        .rd_data  (out_res)
    );

    assign m_pin_level = out_res.pin_level;
    assign m_busy_res  = out_res.busy_res;
    assign m_accepted  = out_res.accepted;
    assign m_all_done  = out_res.all_done;

endmodule

>>> src/ooke_cfg_regs.sv
// Configuration register bank of the pulse train encoder.
// Depends on ooke_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module ooke_cfg_regs
    import ooke_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index; indexes beyond the list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_UNIT_TICKS:      cfg_next.unit_ticks      = wr_data[UNIT_W-1:0];
                CFG_START_GAP_TICKS: cfg_next.start_gap_ticks = wr_data[GAP_W-1:0];
                CFG_STOP_GAP_TICKS:  cfg_next.stop_gap_ticks  = wr_data[GAP_W-1:0];
                CFG_REPEAT_COUNT:    cfg_next.repeat_count    = wr_data[REP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_ticks      <= UNIT_TICKS_RST;
            cfg_reg.start_gap_ticks <= START_GAP_TICKS_RST;
            cfg_reg.stop_gap_ticks  <= STOP_GAP_TICKS_RST;
            cfg_reg.repeat_count    <= REPEAT_COUNT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/ooke_seq.sv
// Frame sequencer: phase, segment and tick counters plus the shifting word.
// Each accepted beat is resolved in one pass of logic. Depends on ooke_pkg.
`timescale 1ns / 1ps

module ooke_seq
    import ooke_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic                 req_type,
    input  logic [IN_WORD_W-1:0] word,
    input  cfg_t                 cfg,
    output res_t                 res
);

    // Frame phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_STOP  = 3'd3;

    logic [2:0]           phase_reg, phase_next;
    logic [WORD_BITS-1:0] shift_word_reg, shift_word_next;
    logic [BITPOS_W-1:0]  bit_position_reg, bit_position_next;
    logic [1:0]           segment_reg, segment_next;
    logic [TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic [REP_W-1:0]     repeats_left_reg, repeats_left_next;

    logic [UNIT_W-1:0] unit_len;
    logic [GAP_W-1:0]  start_len;
    logic [GAP_W-1:0]  stop_len;
    logic [LEN_W-1:0]  unit_long;
    logic [LEN_W-1:0]  seg_len;
    logic [LEN_W-1:0]  tick_plus;
    logic              long_seg;
    logic              seg_end;
    logic              cur_level;
    logic              idle;

    // Zero lengths count as one tick.
    assign unit_len  = (cfg.unit_ticks == '0)      ? UNIT_W'(1) : cfg.unit_ticks;
    assign start_len = (cfg.start_gap_ticks == '0) ? GAP_W'(1)  : cfg.start_gap_ticks;
    assign stop_len  = (cfg.stop_gap_ticks == '0)  ? GAP_W'(1)  : cfg.stop_gap_ticks;

    // Five units as shift and add.
    assign unit_long = LEN_W'({unit_len, 2'b00}) + LEN_W'(unit_len);

    // The first low segment of a bit is long for a one and the second for a zero.
    assign long_seg = shift_word_reg[WORD_BITS-1] ^ segment_reg[1];

    // Length of the segment now being driven.
    always_comb begin
        if (!segment_reg[0]) begin
            seg_len = LEN_W'(unit_len);
        end else begin
            case (phase_reg)
                PH_START: seg_len = LEN_W'(start_len);
                PH_STOP:  seg_len = LEN_W'(stop_len);
                default:  seg_len = long_seg ? unit_long : LEN_W'(unit_len);
            endcase
        end
    end

    assign idle      = (phase_reg == PH_IDLE);
    assign cur_level = !idle && !segment_reg[0];
    assign tick_plus = LEN_W'(tick_count_reg) + LEN_W'(1);
    assign seg_end   = (tick_plus >= seg_len);

    // Next state and the result of the beat.
    always_comb begin
        phase_next        = phase_reg;
        shift_word_next   = shift_word_reg;
        bit_position_next = bit_position_reg;
        segment_next      = segment_reg;
        tick_count_next   = tick_count_reg;
        repeats_left_next = repeats_left_reg;
        res               = '0;

        if (req_type == REQ_LOAD) begin
            res.busy_res = 1'b1;
            if (idle) begin
                shift_word_next   = WORD_BITS'(word);
                repeats_left_next = (cfg.repeat_count == '0) ? REP_W'(1) : cfg.repeat_count;
                phase_next        = PH_START;
                segment_next      = 2'd0;
                bit_position_next = '0;
                tick_count_next   = '0;
                res.accepted      = 1'b1;
                res.pin_level     = 1'b1;
            end else begin
                res.pin_level = cur_level;
            end
        end else if (!idle) begin
            res.pin_level = cur_level;
            res.busy_res  = 1'b1;
            if (!seg_end) begin
                tick_count_next = tick_plus[TICK_W-1:0];
            end else begin
                tick_count_next = '0;
                case (phase_reg)
                    PH_START: begin
                        if (segment_reg == 2'd0) begin
                            segment_next = 2'd1;
                        end else begin
                            phase_next        = PH_DATA;
                            segment_next      = 2'd0;
                            bit_position_next = '0;
                        end
                    end
                    PH_DATA: begin
                        if (segment_reg != 2'd3) begin
                            segment_next = segment_reg + 2'd1;
                        end else begin
                            segment_next = 2'd0;
                            if (bit_position_reg == BITPOS_W'(WORD_BITS - 1)) begin
                                phase_next        = PH_STOP;
                                bit_position_next = '0;
                            end else begin
                                bit_position_next = bit_position_reg + BITPOS_W'(1);
                                shift_word_next   = {shift_word_reg[WORD_BITS-2:0], 1'b0};
                            end
                        end
                    end
                    default: begin
                        // Stop pulse, then the stop gap ends the frame.
                        if (segment_reg == 2'd0) begin
                            segment_next = 2'd1;
                        end else begin
                            segment_next = 2'd0;
                            if (repeats_left_reg > REP_W'(1)) begin
                                repeats_left_next = repeats_left_reg - REP_W'(1);
                                phase_next        = PH_START;
                            end else begin
                                repeats_left_next = '0;
                                phase_next        = PH_IDLE;
                                res.all_done      = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // State registers advance only on an accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            shift_word_reg   <= '0;
            bit_position_reg <= '0;
            segment_reg      <= 2'd0;
            tick_count_reg   <= '0;
            repeats_left_reg <= '0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            shift_word_reg   <= shift_word_next;
            bit_position_reg <= bit_position_next;
            segment_reg      <= segment_next;
            tick_count_reg   <= tick_count_next;
            repeats_left_reg <= repeats_left_next;
        end
    end

    // The repeat counter is zero exactly when no transmission is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) == (repeats_left_reg == '0))
        else $error("repeat counter out of step with phase");

    // Start and stop pulses only use their first two segments.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_START || phase_reg == PH_STOP) |->
            (!segment_reg[1] && bit_position_reg == '0))
        else $error("bad segment or bit position outside the data phase");

    // The final tick of a transmission leaves the block idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && res.all_done) |=> (phase_reg == PH_IDLE))
        else $error("block still busy after the last tick");

endmodule

>>> src/ooke_out_buf.sv
// Two-entry result buffer that decouples the result channel from the input.
// Depends on ooke_pkg for the result beat type.
`timescale 1ns / 1ps

module ooke_out_buf
    import ooke_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  res_t wr_data,
    output logic not_full,
    output logic rd_valid,
    input  logic rd_en,
    output res_t rd_data
);

    res_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_rd;

    assign not_full = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !do_rd) begin
            count_next = count_reg + 2'd1;
        end else if (!wr_en && do_rd) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
